// File: hdl/fmpt_pkg.sv
// shared types and codes for the first-match policy table
`timescale 1ns / 1ps

package fmpt_pkg;

  localparam int MAX_RULES_DEF = 16;
  localparam int CNT_W         = 64;

  // op codes
  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_SET_EN  = 3'd2;
  localparam logic [2:0] OP_EVAL    = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;
  localparam logic [2:0] OP_CLR_CNT = 3'd5;
  localparam logic [2:0] OP_CLR_TBL = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NORATE   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_NOMATCH  = 3'd6;

  localparam logic [2:0] ACT_RATE_LIMIT = 3'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  rule_tag;
    logic [7:0]  event_type;
    logic [2:0]  rule_action;
    logic [31:0] packet_rate;
    logic        enable_bit;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       hit_tag;
    logic [2:0]       hit_action;
    logic [31:0]      hit_rate;
    logic [CNT_W-1:0] hit_total;
    logic [7:0]       echo_type;
  } out_t;

  // one stored rule, hit counter lives in its own memory
  typedef struct packed {
    logic [7:0]  tag;
    logic [7:0]  etype;
    logic [2:0]  action;
    logic [31:0] rate;
    logic        enable;
  } rule_t;

  // finished result handed from the sequencer to the output stage
  typedef struct packed {
    logic valid;
    out_t data;
  } res_chan_t;

endpackage

// File: hdl/fmpt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module fmpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/fmpt_ctrl.sv
// rule table sequencer: scan, compaction and counter update over the rule memories
`timescale 1ns / 1ps

module fmpt_ctrl #(
  parameter int MAX_RULES = fmpt_pkg::MAX_RULES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fmpt_pkg::in_t       in_data,
  output fmpt_pkg::res_chan_t res,
  input  logic                res_take
);

  import fmpt_pkg::*;

  localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW = $clog2(MAX_RULES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  in_t                   req_r, req_nxt;
  out_t                  res_r, res_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         iss_r, iss_nxt;
  logic [IW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  pend_r, pend_nxt;
  logic                  pend_cv_r, pend_cv_nxt;
  logic [MAX_RULES-1:0]  cv_r, cv_nxt;

  logic                  rule_we, cnt_we;
  logic [IW-1:0]         waddr, raddr;
  rule_t                 rule_wdata, rule_rdata;
  logic [CNT_W-1:0]      cnt_wdata, cnt_rdata, cur_cnt;
  logic                  hit, issue_ok;

  fmpt_ram #(.WIDTH($bits(rule_t)), .DEPTH(MAX_RULES), .AW(IW)) u_rule_ram (
    .clk   (clk),
    .we    (rule_we),
    .waddr (waddr),
    .wdata (rule_wdata),
    .raddr (raddr),
    .rdata (rule_rdata)
  );

  fmpt_ram #(.WIDTH(CNT_W), .DEPTH(MAX_RULES), .AW(IW)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rdata)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign res.valid  = (state_r == S_DONE);
  assign res.data   = res_r;
  assign raddr      = iss_r[IW-1:0];
  assign issue_ok   = (iss_r < count_r);
  // counter of a slot that was cleared since its last write reads as zero
  assign cur_cnt    = pend_cv_r ? cnt_rdata : '0;
  assign hit        = pend_r && ((req_r.op == OP_EVAL) ?
                      (rule_rdata.enable && (rule_rdata.etype == req_r.event_type)) :
                      (rule_rdata.tag == req_r.rule_tag));

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    res_nxt     = res_r;
    count_nxt   = count_r;
    iss_nxt     = iss_r;
    rd_idx_nxt  = rd_idx_r;
    pend_nxt    = pend_r;
    pend_cv_nxt = pend_cv_r;
    cv_nxt      = cv_r;
    rule_we     = 1'b0;
    cnt_we      = 1'b0;
    waddr       = rd_idx_r;
    rule_wdata  = rule_rdata;
    cnt_wdata   = cnt_rdata;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data;
          res_nxt  = '0;
          iss_nxt  = '0;
          pend_nxt = 1'b0;
          case (in_data.op)
            OP_ADD: begin
              res_nxt.hit_tag = in_data.rule_tag;
              if (in_data.rule_tag == 8'd0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_DONE;
              end else if ((in_data.rule_action == ACT_RATE_LIMIT) &&
                           (in_data.packet_rate == 32'd0)) begin
                res_nxt.status = ST_NORATE;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_REMOVE, OP_SET_EN, OP_QUERY: begin
              res_nxt.hit_tag = in_data.rule_tag;
              state_nxt       = S_SCAN;
            end
            OP_EVAL: begin
              res_nxt.echo_type = in_data.event_type;
              state_nxt         = S_SCAN;
            end
            OP_CLR_CNT: begin
              cv_nxt    = '0;
              state_nxt = S_DONE;
            end
            OP_CLR_TBL: begin
              cv_nxt    = '0;
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          state_nxt = S_DONE;
          case (req_r.op)
            OP_ADD: begin
              res_nxt.status = ST_DUP;
            end
            OP_REMOVE: begin
              iss_nxt   = CW'(rd_idx_r) + CW'(1);
              pend_nxt  = 1'b0;
              state_nxt = S_SHIFT;
            end
            OP_SET_EN: begin
              rule_we           = 1'b1;
              rule_wdata.enable = req_r.enable_bit;
            end
            OP_EVAL: begin
              cnt_we               = 1'b1;
              cnt_wdata            = cur_cnt + CNT_W'(1);
              cv_nxt[rd_idx_r]     = 1'b1;
              res_nxt.status       = ST_OK;
              res_nxt.hit_tag      = rule_rdata.tag;
              res_nxt.hit_action   = rule_rdata.action;
              res_nxt.hit_rate     = rule_rdata.rate;
              res_nxt.hit_total    = cur_cnt + CNT_W'(1);
            end
            OP_QUERY: begin
              res_nxt.hit_total = cur_cnt;
            end
            default: begin
            end
          endcase
        end else if (!issue_ok) begin
          state_nxt = S_DONE;
          case (req_r.op)
            OP_ADD: begin
              if (count_r >= CW'(MAX_RULES)) begin
                res_nxt.status = ST_FULL;
              end else begin
                rule_we                   = 1'b1;
                waddr                     = count_r[IW-1:0];
                rule_wdata.tag            = req_r.rule_tag;
                rule_wdata.etype          = req_r.event_type;
                rule_wdata.action         = req_r.rule_action;
                rule_wdata.rate           = req_r.packet_rate;
                rule_wdata.enable         = req_r.enable_bit;
                cv_nxt[count_r[IW-1:0]]   = 1'b0;
                count_nxt                 = count_r + CW'(1);
              end
            end
            OP_EVAL: begin
              res_nxt.status = ST_NOMATCH;
            end
            default: begin
              res_nxt.status = ST_NOTFOUND;
            end
          endcase
        end else begin
          pend_nxt    = 1'b1;
          rd_idx_nxt  = iss_r[IW-1:0];
          pend_cv_nxt = cv_r[iss_r[IW-1:0]];
          iss_nxt     = iss_r + CW'(1);
        end
      end

      // move entry i+1 down to i, one entry a cycle
      S_SHIFT: begin
        if (pend_r) begin
          rule_we        = 1'b1;
          cnt_we         = 1'b1;
          waddr          = rd_idx_r - IW'(1);
          cv_nxt[waddr]  = pend_cv_r;
        end
        if (issue_ok) begin
          pend_nxt    = 1'b1;
          rd_idx_nxt  = iss_r[IW-1:0];
          pend_cv_nxt = cv_r[iss_r[IW-1:0]];
          iss_nxt     = iss_r + CW'(1);
        end else begin
          pend_nxt  = 1'b0;
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cv_r    <= '0;
      pend_r  <= 1'b0;
      iss_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cv_r    <= cv_nxt;
      pend_r  <= pend_nxt;
      iss_r   <= iss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    rd_idx_r  <= rd_idx_nxt;
    pend_cv_r <= pend_cv_nxt;
  end

endmodule

// File: hdl/first_match_policy_table.sv
// top level of the first-match policy table with per-rule hit counters
`timescale 1ns / 1ps

// Usage: requests arrive on in_valid / in_stall / in_data, results leave on
// out_valid / out_stall / out_data, one result per request, in order.
// One request is worked at a time; in_stall is high from the cycle after a
// request is taken until its result has moved into the output register.
// The rules sit in a registered-read memory and are scanned one entry per
// cycle by add, remove, set enable, query and evaluate, from index 0 up to
// the first entry that hits or to the end of the table. Remove then copies
// each later entry down one slot, one per cycle.
// Clear counters, clear table, empty-id and missing-rate rejects skip the
// scan and go straight to the result. Hit counters are 64 bits wide and wrap.
// Reset empties the table and zeroes all counters at once; no sweep is run.
// While out_stall is high the result waits in the output register and a new
// request may still be taken and worked; its result is held until the output
// register is free.

module first_match_policy_table #(
  parameter int MAX_RULES = fmpt_pkg::MAX_RULES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  fmpt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output fmpt_pkg::out_t out_data
);

  import fmpt_pkg::*;

  res_chan_t res;
  logic      res_take;
  logic      out_valid_r, out_valid_nxt;
  out_t      out_data_r, out_data_nxt;

  fmpt_ctrl #(.MAX_RULES(MAX_RULES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .res      (res),
    .res_take (res_take)
  );

  assign res_take  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res.valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res.data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // one request in flight: a taken request blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // a pending result keeps the input side closed
  a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> in_stall)
    else $error("input open while a result is pending");

  // a handed-over result shows up at the output next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res_take) |=> (out_valid && (out_data == $past(res.data))))
    else $error("result lost on its way to the output register");

endmodule

// File: bench/first_match_policy_table_test.sv
// self-checking testbench for the first-match policy table
`timescale 1ns / 1ps

module first_match_policy_table_test;
  import fmpt_pkg::*;

  localparam int          RULE_SLOTS  = MAX_RULES_DEF;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          RANDOM_REQS = 700;
  localparam logic [2:0]  OP_UNUSED   = 3'd7;
  localparam logic [2:0]  ACT_ALLOW   = 3'd0;
  localparam logic [2:0]  ACT_DROP    = 3'd1;
  localparam logic [2:0]  ACT_SPARE_6 = 3'd6;
  localparam logic [2:0]  ACT_SPARE_7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  first_match_policy_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_t  pending_requests[$];
  out_t expected_results[$];
  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  bit          req_taken = 1'b0;

  // shadow copy of the rule list
  rule_t       shadow_rules [RULE_SLOTS];
  logic [63:0] shadow_hits [RULE_SLOTS];
  int unsigned shadow_count = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int find_rule(logic [7:0] tag);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_rules[i].tag == tag) return i;
    end
    return -1;
  endfunction

  // applies one request to the shadow list and returns the result it must give
  function automatic out_t rule_lookup_result(in_t req);
    out_t res;
    int   slot;
    res = '0;
    case (req.op)
      OP_ADD: begin
        res.hit_tag = req.rule_tag;
        if (req.rule_tag == 8'd0) res.status = ST_EMPTY;
        else if (req.rule_action == ACT_RATE_LIMIT && req.packet_rate == 32'd0)
          res.status = ST_NORATE;
        else if (find_rule(req.rule_tag) >= 0) res.status = ST_DUP;
        else if (shadow_count >= RULE_SLOTS) res.status = ST_FULL;
        else begin
          res.status = ST_OK;
          shadow_rules[shadow_count] = '{tag: req.rule_tag, etype: req.event_type,
                                         action: req.rule_action, rate: req.packet_rate,
                                         enable: req.enable_bit};
          shadow_hits[shadow_count] = '0;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        res.hit_tag = req.rule_tag;
        slot = find_rule(req.rule_tag);
        if (slot < 0) res.status = ST_NOTFOUND;
        else begin
          for (int i = slot; i + 1 < shadow_count; i++) begin
            shadow_rules[i] = shadow_rules[i+1];
            shadow_hits[i]  = shadow_hits[i+1];
          end
          shadow_count--;
          res.status = ST_OK;
        end
      end
      OP_SET_EN: begin
        res.hit_tag = req.rule_tag;
        slot = find_rule(req.rule_tag);
        if (slot < 0) res.status = ST_NOTFOUND;
        else begin
          shadow_rules[slot].enable = req.enable_bit;
          res.status = ST_OK;
        end
      end
      OP_EVAL: begin
        res.echo_type = req.event_type;
        res.status = ST_NOMATCH;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_rules[i].enable && shadow_rules[i].etype == req.event_type) begin
            shadow_hits[i] = shadow_hits[i] + 64'd1;
            res.status     = ST_OK;
            res.hit_tag    = shadow_rules[i].tag;
            res.hit_action = shadow_rules[i].action;
            res.hit_rate   = shadow_rules[i].rate;
            res.hit_total  = shadow_hits[i];
            break;
          end
        end
      end
      OP_QUERY: begin
        res.hit_tag = req.rule_tag;
        slot = find_rule(req.rule_tag);
        if (slot < 0) res.status = ST_NOTFOUND;
        else begin
          res.status    = ST_OK;
          res.hit_total = shadow_hits[slot];
        end
      end
      OP_CLR_CNT: begin
        for (int i = 0; i < RULE_SLOTS; i++) shadow_hits[i] = '0;
      end
      OP_CLR_TBL: begin
        shadow_count = 0;
        for (int i = 0; i < RULE_SLOTS; i++) shadow_hits[i] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  function automatic void push_req(logic [2:0] op, logic [7:0] tag, logic [7:0] etype,
                                   logic [2:0] act, logic [31:0] rate, logic en);
    in_t req;
    req = '{op: op, rule_tag: tag, event_type: etype, rule_action: act,
            packet_rate: rate, enable_bit: en};
    pending_requests.insert(pending_requests.size(), req);
  endfunction

  function automatic logic [31:0] pick_rate();
    if ($urandom_range(0, 9) == 0) return 32'd0;
    return $urandom;
  endfunction

  // request side: acceptance, prediction and the idle watchdog
  always @(posedge clk) begin
    req_taken = rst_n && in_valid && !in_stall;
    if (req_taken)
      expected_results.insert(expected_results.size(), rule_lookup_result(in_data));
    if (rst_n) begin
      if (req_taken || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // driver
  int unsigned send_gap = 0;
  always @(negedge clk) begin
    if (rst_n && (req_taken || !in_valid)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall pattern, with two long hold-offs to back up the block
  int unsigned hold_left = 0, stall_left = 0, free_left = 0, holds_done = 0;
  always @(negedge clk) begin
    if (holds_done < 2 && results_seen >= 150 + holds_done * 300) begin
      hold_left = 250;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      stall_left = pick_gap();
      free_left  = $urandom_range(0, 12);
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          flag_error($sformatf("result %0d status %0d, want %0d",
                               results_seen, out_data.status, want.status));
        if (out_data.hit_tag !== want.hit_tag)
          flag_error($sformatf("result %0d hit_tag %0d, want %0d",
                               results_seen, out_data.hit_tag, want.hit_tag));
        if (out_data.hit_action !== want.hit_action)
          flag_error($sformatf("result %0d hit_action %0d, want %0d",
                               results_seen, out_data.hit_action, want.hit_action));
        if (out_data.hit_rate !== want.hit_rate)
          flag_error($sformatf("result %0d hit_rate %h, want %h",
                               results_seen, out_data.hit_rate, want.hit_rate));
        if (out_data.hit_total !== want.hit_total)
          flag_error($sformatf("result %0d hit_total %0d, want %0d",
                               results_seen, out_data.hit_total, want.hit_total));
        if (out_data.echo_type !== want.echo_type)
          flag_error($sformatf("result %0d echo_type %0d, want %0d",
                               results_seen, out_data.echo_type, want.echo_type));
      end
    end
  end

  initial begin
    int unsigned target, kind, n, base;
    bit          distinct;
    for (int i = 0; i < RULE_SLOTS; i++) shadow_hits[i] = '0;

    // directed part: rejects in their priority order, spare actions, misses
    push_req(OP_CLR_TBL, 8'd0, 8'd0, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_ADD, 8'd0, 8'd5, ACT_RATE_LIMIT, 32'd0, 1'b1);
    push_req(OP_ADD, 8'd1, 8'd5, ACT_RATE_LIMIT, 32'd0, 1'b1);
    push_req(OP_ADD, 8'd255, 8'd255, ACT_SPARE_7, 32'hFFFF_FFFF, 1'b1);
    push_req(OP_ADD, 8'd255, 8'd0, ACT_DROP, 32'd7, 1'b1);
    push_req(OP_ADD, 8'd255, 8'd0, ACT_RATE_LIMIT, 32'd0, 1'b1);
    push_req(OP_ADD, 8'd1, 8'd0, ACT_SPARE_6, 32'd0, 1'b0);
    push_req(OP_ADD, 8'd2, 8'd0, ACT_RATE_LIMIT, 32'd1, 1'b1);
    push_req(OP_EVAL, 8'd0, 8'd0, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_SET_EN, 8'd1, 8'd0, ACT_ALLOW, 32'd0, 1'b1);
    push_req(OP_EVAL, 8'hAA, 8'd0, ACT_SPARE_7, 32'hFFFF_FFFF, 1'b1);
    push_req(OP_EVAL, 8'd0, 8'd255, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_EVAL, 8'd0, 8'd255, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_EVAL, 8'd0, 8'd77, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_QUERY, 8'd255, 8'd0, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_QUERY, 8'd0, 8'd0, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_REMOVE, 8'd0, 8'd0, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_SET_EN, 8'd9, 8'd0, ACT_ALLOW, 32'd0, 1'b1);
    push_req(OP_REMOVE, 8'd1, 8'd0, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_EVAL, 8'd0, 8'd0, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_UNUSED, 8'hFF, 8'hFF, ACT_SPARE_7, 32'hFFFF_FFFF, 1'b1);
    push_req(OP_CLR_CNT, 8'd0, 8'd0, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_QUERY, 8'd255, 8'd0, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_CLR_TBL, 8'd0, 8'd0, ACT_ALLOW, 32'd0, 1'b0);
    push_req(OP_QUERY, 8'd255, 8'd0, ACT_ALLOW, 32'd0, 1'b0);

    // random part: mostly rule-set loads followed by traffic, plus noise
    target = pending_requests.size() + RANDOM_REQS;
    while (pending_requests.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        if ($urandom_range(0, 3) == 0)
          push_req(OP_CLR_CNT, 8'($urandom), 8'($urandom), 3'($urandom), $urandom,
                   1'($urandom));
        else
          push_req(OP_CLR_TBL, 8'($urandom), 8'($urandom), 3'($urandom), $urandom,
                   1'($urandom));
        distinct = ($urandom_range(0, 2) == 0);
        n = distinct ? $urandom_range(14, 20) : $urandom_range(2, 10);
        base = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
          push_req(OP_ADD, distinct ? 8'(base + i) : 8'($urandom_range(1, 25)),
                   8'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), pick_rate(),
                   $urandom_range(0, 5) != 0);
        end
      end else if (kind < 65) begin
        n = $urandom_range(4, 12);
        for (int i = 0; i < n; i++) begin
          push_req(OP_EVAL, 8'($urandom),
                   8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 4)),
                   3'($urandom), $urandom, 1'($urandom));
        end
      end else if (kind < 75) begin
        push_req(OP_SET_EN, 8'($urandom_range(0, 25)), 8'($urandom), 3'($urandom),
                 $urandom, 1'($urandom));
      end else if (kind < 82) begin
        push_req(OP_QUERY, 8'($urandom_range(0, 25)), 8'($urandom), 3'($urandom),
                 $urandom, 1'($urandom));
      end else if (kind < 88) begin
        push_req(OP_REMOVE, 8'($urandom_range(0, 25)), 8'($urandom), 3'($urandom),
                 $urandom, 1'($urandom));
      end else if (kind < 93) begin
        push_req(OP_ADD, 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 25)),
                 8'($urandom_range(0, 4)), 3'($urandom_range(0, 7)), pick_rate(),
                 1'($urandom));
      end else begin
        push_req(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 3'($urandom),
                 $urandom, 1'($urandom));
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
